/* src/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// shared types and constants of the shortest path engine
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int VTX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int DIST_W     = 22;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 256;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_VERTEX = 1'b1;

  localparam logic [CNT_W-1:0]  VC_RESET = 7'd64;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_POP,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_VISIT,
    S_LIST,
    S_EDGE,
    S_RELAX,
    S_UP_RD,
    S_UP_CMP,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT
  } ssp_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_list;
    logic rd_edge;
  } ssp_es_ctl_t;

endpackage

`default_nettype wire

/* src/single_source_shortest_path_engine.sv */
// ----------------------------------------------------------------------------
// single_source_shortest_path_engine
// shortest paths from one vertex over a loaded edge list, binary heap search
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries commands. a load command (in_command 0) appends one
//   edge to the tail vertex's list; loads transfer one per cycle while idle.
//   a run command (in_command 1) starts the search; in_ready stays low from
//   then until the last result has been loaded into the output register.
//   the search pops the heap, sifts down, walks the popped vertex's edges
//   and sifts improved entries up; the heap is held twice, the distance
//   memory once, each with one read port. results follow on out_*, one per
//   vertex in vertex order, each read before it is loaded; out_last marks
//   the final one and the edge store is emptied with it. a stall on
//   out_ready holds the output register and pauses the sequence. cfg_we
//   writes vertex_count (index 0) or source_vertex (index 1); the user must
//   write only while idle, which the block does not enforce. reset empties
//   all lists, sets vertex_count 64 and source 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_path_engine #(
  parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = ssp_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = ssp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [ssp_pkg::VTX_W-1:0]       in_from_vertex,
  input  wire logic [ssp_pkg::VTX_W-1:0]       in_to_vertex,
  input  wire logic [ssp_pkg::WIN_W-1:0]       in_weight,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ssp_pkg::VTX_W-1:0]            out_vertex,
  output logic [ssp_pkg::DIST_W-1:0]           out_path_length,
  output logic [ssp_pkg::VTX_W-1:0]            out_predecessor,
  output logic                                 out_reachable,
  output logic                                 out_last
);

  import ssp_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int WXW = WEIGHT_BITS + WIN_W;

  logic [CNT_W-1:0] vc_r, vc_nxt;
  logic [VTX_W-1:0] src_r, src_nxt;
  logic [CNT_W-1:0] n;
  logic [VW-1:0]    src_eff;
  logic             busy, xfer, ld, start;
  logic [WXW-1:0]   wx;
  ssp_es_ctl_t      es_ctl, s_ctl;
  logic [VW-1:0]    list_vtx, edge_tgt;
  logic [EW-1:0]    edge_idx, list_head, list_tail, edge_link;
  logic             list_ok;
  logic [WEIGHT_BITS-1:0] edge_cost;

  always_comb begin
    vc_nxt  = vc_r;
    src_nxt = src_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT:  vc_nxt  = cfg_data;
        CFG_SOURCE_VERTEX: src_nxt = cfg_data[VTX_W-1:0];
        default: begin
          vc_nxt = vc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= VC_RESET;
      src_r <= '0;
    end else begin
      vc_r  <= vc_nxt;
      src_r <= src_nxt;
    end
  end

  always_comb begin
    if (vc_r == '0) begin
      n = CNT_W'(1);
    end else if (vc_r > CNT_W'(MAX_VERTICES)) begin
      n = CNT_W'(MAX_VERTICES);
    end else begin
      n = vc_r;
    end
  end

  assign src_eff  = ({1'b0, src_r} < n) ? src_r[VW-1:0] : '0;
  assign in_ready = !busy;
  assign xfer     = in_valid && in_ready;
  assign ld       = xfer && (in_command == CMD_LOAD);
  assign start    = xfer && (in_command == CMD_RUN);
  assign wx       = WXW'(in_weight);

  assign es_ctl = '{load: ld, clear: s_ctl.clear, rd_list: s_ctl.rd_list,
                    rd_edge: s_ctl.rd_edge};

  ssp_edge_store #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_edge_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (es_ctl),
    .n         (n),
    .ld_from   (in_from_vertex),
    .ld_to     (in_to_vertex),
    .ld_cost   (wx[WEIGHT_BITS-1:0]),
    .list_vtx  (list_vtx),
    .edge_idx  (edge_idx),
    .list_ok   (list_ok),
    .list_head (list_head),
    .list_tail (list_tail),
    .edge_tgt  (edge_tgt),
    .edge_cost (edge_cost),
    .edge_link (edge_link)
  );

  ssp_search #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_search (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .n               (n),
    .src             (src_eff),
    .es_ctl          (s_ctl),
    .list_vtx        (list_vtx),
    .edge_idx        (edge_idx),
    .list_ok         (list_ok),
    .list_head       (list_head),
    .list_tail       (list_tail),
    .edge_tgt        (edge_tgt),
    .edge_cost       (edge_cost),
    .edge_link       (edge_link),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_vertex      (out_vertex),
    .out_path_length (out_path_length),
    .out_predecessor (out_predecessor),
    .out_reachable   (out_reachable),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

/* src/ssp_ram.sv */
// ----------------------------------------------------------------------------
// ssp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/ssp_edge_store.sv */
// ----------------------------------------------------------------------------
// ssp_edge_store
// adjacency lists: edge, link, head and tail memories with the load pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_edge_store #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire ssp_pkg::ssp_es_ctl_t                        ctl,
  input  wire logic [ssp_pkg::CNT_W-1:0]                   n,
  input  wire logic [ssp_pkg::VTX_W-1:0]                   ld_from,
  input  wire logic [ssp_pkg::VTX_W-1:0]                   ld_to,
  input  wire logic [WEIGHT_BITS-1:0]                      ld_cost,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             list_vtx,
  input  wire logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_idx,
  output logic                                             list_ok,
  output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] list_head,
  output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] list_tail,
  output logic [$clog2(MAX_VERTICES)-1:0]                  edge_tgt,
  output logic [WEIGHT_BITS-1:0]                           edge_cost,
  output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_link
);

  import ssp_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EW  = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);

  logic [ECW-1:0]          ecnt_r, ecnt_nxt;
  logic [MAX_VERTICES-1:0] hv_r, hv_nxt;
  logic                    p1_r, p1_nxt;
  logic [EW-1:0]           p1_e_r;
  logic                    list_ok_r;
  logic                    full, ok;
  logic [EW-1:0]           e_new;
  logic [VW-1:0]           from_v, to_v;

  assign full   = (ecnt_r == ECW'(MAX_EDGES));
  assign ok     = ctl.load && ({1'b0, ld_from} < n) && ({1'b0, ld_to} < n) && !full;
  assign e_new  = ecnt_r[EW-1:0];
  assign from_v = ld_from[VW-1:0];
  assign to_v   = ld_to[VW-1:0];

  always_comb begin
    ecnt_nxt = ecnt_r;
    hv_nxt   = hv_r;
    p1_nxt   = ok && hv_r[from_v];
    if (ctl.clear) begin
      ecnt_nxt = '0;
      hv_nxt   = '0;
    end else if (ok) begin
      ecnt_nxt         = ecnt_r + 1'b1;
      hv_nxt[from_v]   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
      hv_r   <= '0;
      p1_r   <= 1'b0;
    end else begin
      ecnt_r <= ecnt_nxt;
      hv_r   <= hv_nxt;
      p1_r   <= p1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_e_r <= e_new;
    if (ctl.rd_list) begin
      list_ok_r <= hv_r[list_vtx];
    end
  end

  assign list_ok = list_ok_r;

  ssp_ram #(.WIDTH(VW + WEIGHT_BITS), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (ok),
    .waddr (e_new),
    .wdata ({to_v, ld_cost}),
    .re    (ctl.rd_edge),
    .raddr (edge_idx),
    .rdata ({edge_tgt, edge_cost})
  );

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link_ram (
    .clk   (clk),
    .we    (p1_r),
    .waddr (list_tail),
    .wdata (p1_e_r),
    .re    (ctl.rd_edge),
    .raddr (edge_idx),
    .rdata (edge_link)
  );

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
    .clk   (clk),
    .we    (ok && !hv_r[from_v]),
    .waddr (from_v),
    .wdata (e_new),
    .re    (ctl.rd_list),
    .raddr (list_vtx),
    .rdata (list_head)
  );

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail_ram (
    .clk   (clk),
    .we    (ok),
    .waddr (from_v),
    .wdata (e_new),
    .re    (ok || ctl.rd_list),
    .raddr (ok ? from_v : list_vtx),
    .rdata (list_tail)
  );

endmodule

`default_nettype wire

/* src/ssp_search.sv */
// ----------------------------------------------------------------------------
// ssp_search
// search sequencer: binary heap and distance memories, result output register
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_search #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic [ssp_pkg::CNT_W-1:0]                   n,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             src,
  output ssp_pkg::ssp_es_ctl_t                             es_ctl,
  output logic [$clog2(MAX_VERTICES)-1:0]                  list_vtx,
  output logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_idx,
  input  wire logic                                        list_ok,
  input  wire logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] list_head,
  input  wire logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] list_tail,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]             edge_tgt,
  input  wire logic [WEIGHT_BITS-1:0]                      edge_cost,
  input  wire logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_link,
  output logic                                             busy,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic [ssp_pkg::VTX_W-1:0]                        out_vertex,
  output logic [ssp_pkg::DIST_W-1:0]                       out_path_length,
  output logic [ssp_pkg::VTX_W-1:0]                        out_predecessor,
  output logic                                             out_reachable,
  output logic                                             out_last
);

  import ssp_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int HD = MAX_EDGES + 2;
  localparam int HW = $clog2(HD);
  localparam int HE = DIST_W + VW;
  localparam int SW = (DIST_W > WEIGHT_BITS ? DIST_W : WEIGHT_BITS) + 1;

  ssp_state_t state_r, state_nxt;

  logic [HW-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        vcnt_r, vcnt_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [HE-1:0]           key_r, key_nxt, top_r, top_nxt;
  logic [HW-1:0]           pos_r, pos_nxt;
  logic [EW-1:0]           e_r, e_nxt, tail_r, tail_nxt, link_r, link_nxt;
  logic [VW-1:0]           t_r, t_nxt;
  logic [DIST_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    load_out;
  logic [VTX_W-1:0]        ov_r, op_r;
  logic [DIST_W-1:0]       od_r;
  logic                    orch_r, olast_r;

  logic          h_we, h_re;
  logic [HW-1:0] h_waddr, h_ra, h_rb;
  logic [HE-1:0] h_wdata, qa, qb;
  logic          d_we, d_re;
  logic [VW-1:0] d_waddr, d_raddr;
  logic [HE-1:0] d_wdata, dq;

  logic [HW:0]       lc, rc;
  logic              lv, rv, sel;
  logic [HE-1:0]     cand;
  logic [HW:0]       ci;
  logic [VW-1:0]     u;
  logic [DIST_W-1:0] du;
  logic [SW-1:0]     wsum;
  logic              is_last;

  assign u    = top_r[VW-1:0];
  assign du   = top_r[HE-1:VW];
  assign lc   = {pos_r, 1'b0};
  assign rc   = {pos_r, 1'b1};
  assign lv   = lc <= {1'b0, cnt_r};
  assign rv   = rc <= {1'b0, cnt_r};
  assign wsum = SW'(du) + SW'(edge_cost);
  assign is_last = (i_r + 1'b1) == n;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    vcnt_nxt    = vcnt_r;
    reached_nxt = reached_r;
    visited_nxt = visited_r;
    key_nxt     = key_r;
    top_nxt     = top_r;
    pos_nxt     = pos_r;
    e_nxt       = e_r;
    tail_nxt    = tail_r;
    link_nxt    = link_r;
    t_nxt       = t_r;
    sum_nxt     = sum_r;
    i_nxt       = i_r;
    load_out    = 1'b0;
    es_ctl      = '0;
    list_vtx    = u;
    edge_idx    = list_head;
    h_we        = 1'b0;
    h_re        = 1'b0;
    h_waddr     = pos_r;
    h_wdata     = key_r;
    h_ra        = lc[HW-1:0];
    h_rb        = rc[HW-1:0];
    d_we        = 1'b0;
    d_re        = 1'b0;
    d_waddr     = t_r;
    d_wdata     = {sum_r, u};
    d_raddr     = edge_tgt;
    sel         = 1'b0;
    cand        = key_r;
    ci          = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        reached_nxt      = '0;
        reached_nxt[src] = 1'b1;
        visited_nxt      = '0;
        d_we             = 1'b1;
        d_waddr          = src;
        d_wdata          = {{DIST_W{1'b0}}, src};
        h_we             = 1'b1;
        h_waddr          = HW'(1);
        h_wdata          = {{DIST_W{1'b0}}, src};
        cnt_nxt          = HW'(1);
        vcnt_nxt         = '0;
        state_nxt        = S_CHECK;
      end
      S_CHECK: begin
        if (vcnt_r == n || cnt_r == '0) begin
          i_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          h_re      = 1'b1;
          h_ra      = HW'(1);
          h_rb      = cnt_r;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        top_nxt   = qa;
        key_nxt   = qb;
        cnt_nxt   = cnt_r - 1'b1;
        pos_nxt   = HW'(1);
        state_nxt = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        h_re      = 1'b1;
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        if (lv && qa < key_r) begin
          sel  = 1'b1;
          cand = qa;
          ci   = lc;
        end
        if (rv && qb < cand) begin
          sel  = 1'b1;
          cand = qb;
          ci   = rc;
        end
        h_we    = 1'b1;
        h_wdata = cand;
        if (sel) begin
          pos_nxt   = ci[HW-1:0];
          state_nxt = S_SIFT_RD;
        end else begin
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        if (visited_r[u]) begin
          state_nxt = S_CHECK;
        end else begin
          visited_nxt[u] = 1'b1;
          vcnt_nxt       = vcnt_r + 1'b1;
          es_ctl.rd_list = 1'b1;
          state_nxt      = S_LIST;
        end
      end
      S_LIST: begin
        if (!list_ok) begin
          state_nxt = S_CHECK;
        end else begin
          e_nxt          = list_head;
          tail_nxt       = list_tail;
          es_ctl.rd_edge = 1'b1;
          edge_idx       = list_head;
          state_nxt      = S_EDGE;
        end
      end
      S_EDGE: begin
        t_nxt     = edge_tgt;
        link_nxt  = edge_link;
        sum_nxt   = (wsum > SW'(DIST_MAX)) ? DIST_MAX : wsum[DIST_W-1:0];
        d_re      = 1'b1;
        d_raddr   = edge_tgt;
        state_nxt = S_RELAX;
      end
      S_RELAX: begin
        if (!visited_r[t_r] && (!reached_r[t_r] || sum_r < dq[HE-1:VW])) begin
          d_we            = 1'b1;
          reached_nxt[t_r] = 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
          pos_nxt         = cnt_r + 1'b1;
          key_nxt         = {sum_r, t_r};
          state_nxt       = S_UP_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_UP_RD: begin
        if (pos_r == HW'(1)) begin
          h_we      = 1'b1;
          state_nxt = S_NEXT;
        end else begin
          h_re      = 1'b1;
          h_ra      = pos_r >> 1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        h_we = 1'b1;
        if (key_r < qa) begin
          h_wdata   = qa;
          pos_nxt   = pos_r >> 1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (e_r == tail_r) begin
          state_nxt = S_CHECK;
        end else begin
          e_nxt          = link_r;
          es_ctl.rd_edge = 1'b1;
          edge_idx       = link_r;
          state_nxt      = S_EDGE;
        end
      end
      S_EMIT_RD: begin
        d_re      = 1'b1;
        d_raddr   = i_r[VW-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          i_nxt    = i_r + 1'b1;
          if (is_last) begin
            es_ctl.clear = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      vcnt_r      <= '0;
      reached_r   <= '0;
      visited_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      vcnt_r      <= vcnt_nxt;
      reached_r   <= reached_nxt;
      visited_r   <= visited_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    top_r  <= top_nxt;
    pos_r  <= pos_nxt;
    e_r    <= e_nxt;
    tail_r <= tail_nxt;
    link_r <= link_nxt;
    t_r    <= t_nxt;
    sum_r  <= sum_nxt;
    i_r    <= i_nxt;
    if (load_out) begin
      ov_r    <= VTX_W'(i_r[VW-1:0]);
      orch_r  <= reached_r[i_r[VW-1:0]];
      od_r    <= reached_r[i_r[VW-1:0]] ? dq[HE-1:VW] : '0;
      op_r    <= VTX_W'(reached_r[i_r[VW-1:0]] ? dq[VW-1:0] : src);
      olast_r <= is_last;
    end
  end

  ssp_ram #(.WIDTH(HE), .DEPTH(HD)) u_heap_a (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_ra),
    .rdata (qa)
  );

  ssp_ram #(.WIDTH(HE), .DEPTH(HD)) u_heap_b (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (h_re),
    .raddr (h_rb),
    .rdata (qb)
  );

  ssp_ram #(.WIDTH(HE), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (dq)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_vertex      = ov_r;
  assign out_path_length = od_r;
  assign out_predecessor = op_r;
  assign out_reachable   = orch_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

/* src/ssp_checker.sv */
// ----------------------------------------------------------------------------
// ssp_checker
// port level checks of the shortest path engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_command,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ssp_pkg::VTX_W-1:0]      out_vertex,
  input wire logic [ssp_pkg::DIST_W-1:0]     out_path_length,
  input wire logic                           out_last
);

  import ssp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex)
      && $stable(out_path_length) && $stable(out_last))
    else $error("result changed while stalled");

  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_RUN |=> !in_ready)
    else $error("input taken during run");

  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("engine idle before last result");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind single_source_shortest_path_engine ssp_checker u_ssp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_vertex      (out_vertex),
  .out_path_length (out_path_length),
  .out_last        (out_last)
);

`default_nettype wire
